### rtl/core/eard_pkg.sv
// ----------------------------------------------------------------------------
// eard_pkg
// Shared constants, types and functions for the advertisement readout decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package eard_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_COMPANY  = 3'd2,
        ST_MARKER   = 3'd3,
        ST_KEY      = 3'd4,
        ST_NODATA   = 3'd5
    } status_t;

    localparam logic [7:0]  COMPANY_LO   = 8'hE1;
    localparam logic [7:0]  COMPANY_HI   = 8'h02;
    localparam logic [7:0]  RECORD_MARK  = 8'h10;
    localparam logic [15:0] NO_DATA      = 16'h7FFF;
    localparam logic [4:0]  MIN_FRAME    = 5'd20;
    localparam logic [4:0]  POS_MAX      = 5'd31;
    localparam int          KEY_REG_W    = 64;

    // Configuration register indexes
    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    // Start request and counter block seed for the AES core
    typedef struct packed {
        logic       start;
        logic [15:0] counter;
    } aes_req_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

### rtl/core/encrypted_advert_readout_decoder_top.sv
// ----------------------------------------------------------------------------
// encrypted_advert_readout_decoder_top
// Parses an advertisement payload byte by byte and decrypts the readout.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake       | Payload
// s_      | in        | valid/ready     | data_byte, last_byte
// m_      | out       | valid/ready     | status and readout fields
// cfg     | in        | write enable    | key_high, key_low
//
// Non-final bytes are taken whenever s_ready is high. A final byte of a good
// frame starts the AES core: nine full rounds and a final round without
// MixColumns, paced by the single S-box lookup per cycle; m_valid rises after
// the done pulse and the result then waits in the output register. Short or
// faulty frames report in the next cycle. Reset clears the parser but not
// plain_reg; s_ready stays low while a result is pending or the core is busy.
`default_nettype none
module encrypted_advert_readout_decoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [7:0]       m_device_state,
    output logic [7:0]       m_error_code,
    output logic signed [15:0] m_battery_centivolts,
    output logic signed [15:0] m_battery_deciamps,
    output logic             m_current_valid,
    output logic [15:0]      m_yield_tens_wh,
    output logic [15:0]      m_pv_watts,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [eard_pkg::KEY_REG_W-1:0] cfg_data
);
    import eard_pkg::*;

    logic [63:0]  key_high_reg, key_low_reg;
    logic [4:0]   pos_reg;
    logic [2:0]   fault_reg;
    logic [15:0]  ctr_reg;
    logic [79:0]  plain_reg;   // byte 10 in bits 79:72
    logic         busy_reg;
    logic         m_valid_reg;
    aes_req_t     req;
    logic         aes_done;
    logic [79:0]  ks;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic s_fire;
    logic [2:0] fault_next;
    logic [4:0] pos_next;
    assign s_ready = !busy_reg && !m_valid_reg;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        fault_next = fault_reg;
        if (fault_reg == ST_OK) begin
            if ((pos_reg == 5'd0 && s_data_byte != COMPANY_LO) ||
                (pos_reg == 5'd1 && s_data_byte != COMPANY_HI))
                fault_next = ST_COMPANY;
            else if (pos_reg == 5'd2 && s_data_byte != RECORD_MARK)
                fault_next = ST_MARKER;
            else if (pos_reg == 5'd9 && s_data_byte != key_high_reg[63:56])
                fault_next = ST_KEY;
        end
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 5'd1 : pos_reg;
        req.start   = s_fire && s_last_byte && pos_next >= MIN_FRAME && fault_next == ST_OK;
        req.counter = ctr_reg;
    end

    // decrypted fields
    logic [79:0] d;
    logic [15:0] rv, ra;
    assign d  = plain_reg ^ ks;
    assign rv = {d[55:48], d[63:56]};
    assign ra = {d[39:32], d[47:40]};

    // frame parser and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            fault_reg   <= ST_OK;
            ctr_reg     <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (s_fire) begin
                // frame state returns to idle after the final byte
                fault_reg <= s_last_byte ? ST_OK : fault_next;
                pos_reg   <= s_last_byte ? '0 : pos_next;
                if (s_last_byte) ctr_reg <= '0;
                else if (pos_reg == 5'd7) ctr_reg[7:0] <= s_data_byte;
                else if (pos_reg == 5'd8) ctr_reg[15:8] <= s_data_byte;
                if (pos_reg >= 5'd10 && pos_reg < 5'd20)
                    plain_reg <= {plain_reg[71:0], s_data_byte};
                if (s_last_byte) begin
                    {m_device_state, m_error_code, m_battery_centivolts,
                     m_battery_deciamps, m_current_valid, m_yield_tens_wh,
                     m_pv_watts} <= '0;
                    if (pos_next < MIN_FRAME) begin
                        m_status    <= ST_SHORT;
                        m_valid_reg <= 1'b1;
                    end else if (fault_next != ST_OK) begin
                        m_status    <= fault_next;
                        m_valid_reg <= 1'b1;
                    end else begin
                        busy_reg <= 1'b1;
                    end
                end
            end
            if (aes_done) begin
                busy_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
                if (rv == NO_DATA) begin
                    m_status <= ST_NODATA;
                end else begin
                    m_status             <= ST_OK;
                    m_device_state       <= d[79:72];
                    m_error_code         <= d[71:64];
                    m_battery_centivolts <= rv;
                    m_battery_deciamps   <= (ra == NO_DATA) ? 16'd0 : ra;
                    m_current_valid      <= (ra != NO_DATA);
                    m_yield_tens_wh      <= {d[23:16], d[31:24]};
                    m_pv_watts           <= {d[7:0], d[15:8]};
                end
            end
        end
    end

    assign m_valid = m_valid_reg;

    eard_aes_core u_aes (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .key       ({key_high_reg, key_low_reg}),
        .done      (aes_done),
        .keystream (ks)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && m_valid_reg)) else $error("busy with pending result");
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        aes_done |-> busy_reg) else $error("unexpected keystream");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg) else $error("start lost");

endmodule
`default_nettype wire

### rtl/core/eard_aes_core.sv
// ----------------------------------------------------------------------------
// eard_aes_core
// Byte-serial AES-128 encryption of one counter block: one S-box lookup per
// cycle through the state, the key schedule and MixColumns one column a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module eard_aes_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire eard_pkg::aes_req_t  req,
    input  wire logic [127:0]        key,
    output logic                     done,
    output logic [79:0]              keystream
);
    import eard_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SUB, S_KEY, S_MIX, S_ADD
    } state_t;

    state_t       state_reg;
    logic [127:0] st_reg;      // byte 0 in bits 127:120
    logic [127:0] rk_reg;
    logic [3:0]   round_reg;
    logic [3:0]   cnt_reg;
    logic [7:0]   rcon_reg;
    logic [31:0]  kt_reg;
    logic         done_reg;

    // byte access helper
    function automatic logic [7:0] byt(input logic [127:0] v, input logic [3:0] i);
        return v[127 - 8*i -: 8];
    endfunction

    logic [7:0]   sb_in, sb_out;
    logic [3:0]   src_idx;
    logic [31:0]  col, mcol;

    // ShiftRows source for output byte cnt: row r=cnt[1:0], column c=cnt[3:2]
    always_comb begin
        src_idx = {cnt_reg[3:2] + cnt_reg[1:0], cnt_reg[1:0]};
        case (state_reg)
            S_KEY:   sb_in = byt(rk_reg, {2'd3, cnt_reg[1:0] + 2'd1});
            default: sb_in = byt(st_reg, src_idx);
        endcase
        sb_out = sbox(sb_in);
        col = st_reg[127:96];
        mcol[31:24] = xtime(col[31:24]) ^ xtime(col[23:16]) ^ col[23:16] ^ col[15:8] ^ col[7:0];
        mcol[23:16] = col[31:24] ^ xtime(col[23:16]) ^ xtime(col[15:8]) ^ col[15:8] ^ col[7:0];
        mcol[15:8]  = col[31:24] ^ col[23:16] ^ xtime(col[15:8]) ^ xtime(col[7:0]) ^ col[7:0];
        mcol[7:0]   = xtime(col[31:24]) ^ col[31:24] ^ col[23:16] ^ col[15:8] ^ xtime(col[7:0]);
    end

    // Round sequencer. SubBytes+ShiftRows builds the new state into the
    // shift register old_reg (byte per cycle), so the old state stays readable in st_reg.
    logic [127:0] old_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            round_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            // pulse on the last word of the final round
            done_reg <= (state_reg == S_ADD) && (cnt_reg == 4'd3) && (round_reg == 4'd10);
            case (state_reg)
                S_IDLE: begin
                    if (req.start) begin
                        st_reg    <= {req.counter[7:0], req.counter[15:8], 112'd0} ^ key;
                        rk_reg    <= key;
                        rcon_reg  <= 8'h01;
                        round_reg <= 4'd1;
                        cnt_reg   <= '0;
                        state_reg <= S_SUB;
                    end
                end
                S_SUB: begin
                    // lookup reads st_reg and shifts the result into old_reg
                    old_reg   <= {old_reg[119:0], sbox(byt(st_reg, src_idx))};
                    cnt_reg   <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_reg <= S_KEY;
                    end
                end
                S_KEY: begin
                    if (cnt_reg == 4'd0) begin
                        st_reg <= old_reg;
                    end
                    kt_reg  <= {kt_reg[23:0], sb_out};
                    if (cnt_reg[1:0] == 2'd3) begin
                        cnt_reg   <= '0;
                        state_reg <= (round_reg == 4'd10) ? S_ADD : S_MIX;
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_MIX: begin
                    st_reg  <= {st_reg[95:0], mcol};
                    if (cnt_reg == 4'd3) begin
                        cnt_reg   <= '0;
                        state_reg <= S_ADD;
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_ADD: begin
                    // expand key one word per cycle and xor into state
                    logic [31:0] w;
                    w = rk_reg[127:96] ^ (cnt_reg == 4'd0 ?
                        (kt_reg ^ {rcon_reg, 24'd0}) : rk_reg[31:0]);
                    rk_reg  <= {rk_reg[95:0], w};
                    st_reg  <= {st_reg[95:0], st_reg[127:96] ^ w};
                    if (cnt_reg == 4'd3) begin
                        cnt_reg   <= '0;
                        rcon_reg  <= xtime(rcon_reg);
                        if (round_reg == 4'd10) begin
                            state_reg <= S_IDLE;
                        end else begin
                            round_reg <= round_reg + 4'd1;
                            state_reg <= S_SUB;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done      = done_reg;
    assign keystream = st_reg[127:48];

    property p_idle_quiet;
        @(posedge aclk) disable iff (!aresetn) done_reg |-> state_reg == S_IDLE;
    endproperty
    a_idle_quiet: assert property (p_idle_quiet) else $error("done outside idle");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> (round_reg >= 4'd1 && round_reg <= 4'd10))
        else $error("round out of range");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(done_reg) |-> state_reg == S_IDLE)
        else $error("core restarted without request");

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives advertisement payload frames into the readout decoder and checks
// every status/readout transaction against a cycle-free AES-CTR prediction,
// over several key settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import eard_pkg::*;

    localparam int  SETTLE_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 2_000_000;

    // Frame shapes
    localparam int FR_GOOD    = 0;
    localparam int FR_NODATA  = 1;
    localparam int FR_NOCUR   = 2;
    localparam int FR_BADCO0  = 3;
    localparam int FR_BADCO1  = 4;
    localparam int FR_BADMARK = 5;
    localparam int FR_BADKEY  = 6;
    localparam int FR_NOISE   = 7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } payload_byte_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  device_state;
        logic [7:0]  error_code;
        logic [15:0] centivolts;
        logic [15:0] deciamps;
        logic        current_valid;
        logic [15:0] yield_tens;
        logic [15:0] pv_watts;
    } readout_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [7:0]  m_device_state;
    logic [7:0]  m_error_code;
    logic signed [15:0] m_battery_centivolts;
    logic signed [15:0] m_battery_deciamps;
    logic        m_current_valid;
    logic [15:0] m_yield_tens_wh;
    logic [15:0] m_pv_watts;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = REG_KEY_HIGH;
    logic [KEY_REG_W-1:0] cfg_data = '0;

    encrypted_advert_readout_decoder_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_device_state(m_device_state),
        .m_error_code(m_error_code),
        .m_battery_centivolts(m_battery_centivolts),
        .m_battery_deciamps(m_battery_deciamps),
        .m_current_valid(m_current_valid),
        .m_yield_tens_wh(m_yield_tens_wh), .m_pv_watts(m_pv_watts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    payload_byte_t pending_bytes[$];
    readout_t      expected_readouts[$];
    logic [7:0]    subst[256];
    logic [63:0]   key_hi_shadow = '0;
    logic [63:0]   key_lo_shadow = '0;
    logic          calm = 1'b0;
    int            failures = 0;
    int            frames_sent = 0;
    int            bytes_accepted = 0;
    int            readouts_checked = 0;
    int            status_seen[8];
    longint        cycles = 0;

    // Frame tracking of the prediction
    logic [4:0]  pos_q = '0;
    status_t     fault_q = ST_OK;
    logic [15:0] ctr_q = '0;
    logic [7:0]  plain_q[10];

    // ------------------------------------------------------------------
    // GF(2^8) helpers and AES-128 keystream
    // ------------------------------------------------------------------
    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_dbl(a);
        end
        return acc;
    endfunction

    // Builds the substitution table from the field inverse and the affine map
    task automatic build_subst();
        logic [7:0] inv, p, s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            if (x != 0) begin
                p = 8'h01;
                for (int k = 0; k < 254; k++) p = gf_mul(p, 8'(x));
                inv = p;
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            subst[x] = s;
        end
    endtask

    // Keystream byte i sits at bits [127-8i -: 8]
    function automatic logic [127:0] counter_keystream(input logic [15:0] ctr,
            input logic [63:0] khi, input logic [63:0] klo);
        logic [7:0] st[16], rk[16], t[16], w[4], rc;
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] ks;
        for (int i = 0; i < 8; i++) begin
            rk[i]     = khi[63-8*i -: 8];
            rk[i + 8] = klo[63-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) st[i] = 8'h00;
        st[0] = ctr[7:0];
        st[1] = ctr[15:8];
        for (int i = 0; i < 16; i++) st[i] ^= rk[i];
        rc = 8'h01;
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[r + 4*c] = subst[st[r + 4*((c + r) & 3)]];
            if (rnd != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    t[4*c]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
                    t[4*c+1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
                    t[4*c+2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
                    t[4*c+3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
                end
            end
            // key schedule step
            w[0] = subst[rk[13]] ^ rc;
            w[1] = subst[rk[14]];
            w[2] = subst[rk[15]];
            w[3] = subst[rk[12]];
            for (int i = 0; i < 4; i++) rk[i] ^= w[i];
            for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
            rc = gf_dbl(rc);
            for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++) ks[127-8*i -: 8] = st[i];
        return ks;
    endfunction

    // ------------------------------------------------------------------
    // Per-byte prediction; pushes a readout on the final byte
    // ------------------------------------------------------------------
    task automatic track_byte(input logic [7:0] b, input logic last);
        readout_t    r;
        logic [127:0] ks;
        logic [7:0]  d[10];
        logic [4:0]  p;
        p = pos_q;
        if (fault_q == ST_OK) begin
            if ((p == 0 && b != COMPANY_LO) || (p == 1 && b != COMPANY_HI))
                fault_q = ST_COMPANY;
            else if (p == 2 && b != RECORD_MARK)
                fault_q = ST_MARKER;
            else if (p == 9 && b != key_hi_shadow[63:56])
                fault_q = ST_KEY;
        end
        if (p == 7) ctr_q[7:0] = b;
        else if (p == 8) ctr_q[15:8] = b;
        else if (p >= 10 && p < 20) plain_q[p - 10] = b;
        if (pos_q < POS_MAX) pos_q = pos_q + 5'd1;
        if (!last) return;

        r = '0;
        if (pos_q < MIN_FRAME) begin
            r.status = ST_SHORT;
        end else if (fault_q != ST_OK) begin
            r.status = fault_q;
        end else begin
            ks = counter_keystream(ctr_q, key_hi_shadow, key_lo_shadow);
            for (int i = 0; i < 10; i++) d[i] = plain_q[i] ^ ks[127-8*i -: 8];
            if ({d[3], d[2]} == NO_DATA) begin
                r.status = ST_NODATA;
            end else begin
                r.status        = ST_OK;
                r.device_state  = d[0];
                r.error_code    = d[1];
                r.centivolts    = {d[3], d[2]};
                r.current_valid = ({d[5], d[4]} != NO_DATA);
                r.deciamps      = r.current_valid ? {d[5], d[4]} : 16'h0000;
                r.yield_tens    = {d[7], d[6]};
                r.pv_watts      = {d[9], d[8]};
            end
        end
        expected_readouts.push_back(r);
        pos_q = '0;
        fault_q = ST_OK;
        ctr_q = '0;
    endtask

    // ------------------------------------------------------------------
    // Frame builder
    // ------------------------------------------------------------------
    task automatic queue_frame(input int shape, input int len,
            input logic [15:0] ctr, input logic [7:0] fill);
        logic [7:0] fr[35];
        logic [127:0] ks;
        payload_byte_t pb;
        for (int i = 0; i < 35; i++)
            fr[i] = (fill == 8'h00 || fill == 8'hff) ? fill : 8'($urandom_range(0, 255));
        fr[0] = COMPANY_LO;
        fr[1] = COMPANY_HI;
        fr[2] = RECORD_MARK;
        fr[7] = ctr[7:0];
        fr[8] = ctr[15:8];
        fr[9] = key_hi_shadow[63:56];
        ks = counter_keystream(ctr, key_hi_shadow, key_lo_shadow);
        case (shape)
            FR_NODATA: begin
                fr[12] = ks[127-16 -: 8] ^ NO_DATA[7:0];
                fr[13] = ks[127-24 -: 8] ^ NO_DATA[15:8];
            end
            FR_NOCUR: begin
                fr[14] = ks[127-32 -: 8] ^ NO_DATA[7:0];
                fr[15] = ks[127-40 -: 8] ^ NO_DATA[15:8];
            end
            FR_BADCO0:  fr[0] ^= 8'($urandom_range(1, 255));
            FR_BADCO1:  fr[1] ^= 8'($urandom_range(1, 255));
            FR_BADMARK: fr[2] ^= 8'($urandom_range(1, 255));
            FR_BADKEY:  fr[9] ^= 8'($urandom_range(1, 255));
            FR_NOISE: begin
                for (int i = 0; i < 35; i++) fr[i] = 8'($urandom_range(0, 255));
            end
            default: ;
        endcase
        for (int i = 0; i < len; i++) begin
            pb.data = fr[i];
            pb.last = (i == len - 1);
            pending_bytes.push_back(pb);
        end
        frames_sent++;
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_KEY_HIGH) key_hi_shadow = val;
        else key_lo_shadow = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || s_valid || expected_readouts.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    int send_gap = 0;
    always @(posedge aclk) begin
        payload_byte_t pb;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_byte(s_data_byte, s_last_byte);
                bytes_accepted++;
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    pb = pending_bytes.pop_front();
                    s_valid     <= 1'b1;
                    s_data_byte <= pb.data;
                    s_last_byte <= pb.last;
                    send_gap = calm ? 0 : $urandom_range(0, 15);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and back-pressure
    // ------------------------------------------------------------------
    int recv_stall = 0;
    always @(posedge aclk) begin
        readout_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_readouts.size() == 0) begin
                    $error("unexpected readout transaction, status %0d", m_status);
                    failures++;
                end else begin
                    e = expected_readouts.pop_front();
                    readouts_checked++;
                    status_seen[e.status]++;
                    if (m_status != e.status) begin
                        $error("status exp %0d got %0d", e.status, m_status); failures++;
                    end
                    if (m_device_state != e.device_state) begin
                        $error("device_state exp %h got %h", e.device_state, m_device_state);
                        failures++;
                    end
                    if (m_error_code != e.error_code) begin
                        $error("error_code exp %h got %h", e.error_code, m_error_code);
                        failures++;
                    end
                    if (m_battery_centivolts != e.centivolts) begin
                        $error("battery_centivolts exp %h got %h", e.centivolts,
                               m_battery_centivolts);
                        failures++;
                    end
                    if (m_battery_deciamps != e.deciamps) begin
                        $error("battery_deciamps exp %h got %h", e.deciamps,
                               m_battery_deciamps);
                        failures++;
                    end
                    if (m_current_valid != e.current_valid) begin
                        $error("current_valid exp %b got %b", e.current_valid,
                               m_current_valid);
                        failures++;
                    end
                    if (m_yield_tens_wh != e.yield_tens) begin
                        $error("yield_tens_wh exp %h got %h", e.yield_tens, m_yield_tens_wh);
                        failures++;
                    end
                    if (m_pv_watts != e.pv_watts) begin
                        $error("pv_watts exp %h got %h", e.pv_watts, m_pv_watts);
                        failures++;
                    end
                end
                recv_stall = calm ? 0 : $urandom_range(0, 15);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [63:0] phase_keys[6][2];
        int byte_budget, pick, len;
        build_subst();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset key first, then a mixed key
        queue_frame(FR_GOOD, 20, 16'h0000, 8'h00);
        drain();
        write_reg(REG_KEY_HIGH, 64'hA55A_0F1E_2D3C_4B69);
        write_reg(REG_KEY_LOW,  64'h0123_4567_89AB_CDEF);
        queue_frame(FR_GOOD,    20, 16'hFFFF, 8'hff);
        queue_frame(FR_GOOD,    34, 16'h1234, 8'h5a);   // long frame, position saturates
        queue_frame(FR_GOOD,    19, 16'h0001, 8'h5a);   // one byte short
        queue_frame(FR_GOOD,     1, 16'h0000, 8'h5a);   // lone final byte
        queue_frame(FR_BADCO0,  20, 16'h0102, 8'h5a);
        queue_frame(FR_BADCO1,  20, 16'h0304, 8'h5a);
        queue_frame(FR_BADMARK, 20, 16'h0506, 8'h5a);
        queue_frame(FR_BADKEY,  20, 16'h0708, 8'h5a);
        queue_frame(FR_BADKEY,  12, 16'h0708, 8'h5a);   // short outranks the key fault
        queue_frame(FR_NODATA,  20, 16'h090A, 8'h5a);
        queue_frame(FR_NOCUR,   20, 16'h0B0C, 8'h5a);
        drain();

        phase_keys[0] = '{64'h0, 64'h0};
        phase_keys[1] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        phase_keys[2] = '{{$urandom, $urandom}, {$urandom, $urandom}};
        phase_keys[3] = '{64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE};
        phase_keys[4] = '{{$urandom, $urandom}, {$urandom, $urandom}};
        phase_keys[5] = '{{$urandom, $urandom}, {$urandom, $urandom}};

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_KEY_HIGH, phase_keys[ph][0]);
            write_reg(REG_KEY_LOW,  phase_keys[ph][1]);
            calm = (ph == 2);
            byte_budget = 0;
            while (byte_budget < 165) begin
                pick = $urandom_range(0, 99);
                len  = ($urandom_range(0, 6) == 0) ? $urandom_range(21, 35) : 20;
                if (pick < 55)      queue_frame(FR_GOOD,    len, 16'($urandom), 8'h5a);
                else if (pick < 61) queue_frame(FR_NODATA,  len, 16'($urandom), 8'h5a);
                else if (pick < 67) queue_frame(FR_NOCUR,   len, 16'($urandom), 8'h5a);
                else if (pick < 75) queue_frame(FR_GOOD, $urandom_range(1, 19),
                                                16'($urandom), 8'h5a);
                else if (pick < 79) queue_frame(FR_BADCO0,  len, 16'($urandom), 8'h5a);
                else if (pick < 83) queue_frame(FR_BADCO1,  len, 16'($urandom), 8'h5a);
                else if (pick < 88) queue_frame(FR_BADMARK, len, 16'($urandom), 8'h5a);
                else if (pick < 94) queue_frame(FR_BADKEY,  len, 16'($urandom), 8'h5a);
                else queue_frame(FR_NOISE, $urandom_range(1, 35), 16'($urandom), 8'h5a);
                byte_budget += len;
            end
            drain();
        end

        $display("%0d frames, %0d bytes, %0d readouts checked over 8 key settings",
                 frames_sent, bytes_accepted, readouts_checked);
        $display("status mix ok/short/company/marker/key/nodata: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (failures == 0 && expected_readouts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
